[rtl/core/msdec_pkg.sv]
// ----------------------------------------------------------------------------
// msdec_pkg
// Shared types and constants for the Morse symbol table decoder: command
// codes, field widths and the default tree depth.
// ----------------------------------------------------------------------------
package msdec_pkg;

    // Default number of symbols in the deepest path of the tree.
    localparam int MAX_DEPTH_DEF = 6;

    // Fixed field widths of one input word and one result word.
    localparam int CMD_W  = 2;
    localparam int BITS_W = 6;
    localparam int LEN_W  = 3;
    localparam int CHAR_W = 8;

    // Command codes carried by the command field.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DOT    = 2'd1,
        CMD_DASH   = 2'd2,
        CMD_FINISH = 2'd3
    } t_cmd;

    // Access controls from the walk logic to the table memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tbl_ctrl;

endpackage

[rtl/core/morse_symbol_table_decoder_core.sv]
// ----------------------------------------------------------------------------
// morse_symbol_table_decoder_core
// Dot/dash tree decoder over a heap-ordered character table in one memory.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle whenever busy is low. An insert,
// dot or dash word produces no result. A finish word produces exactly one
// result word, shown with o_valid for one cycle, the cycle after the finish
// word is taken; the character comes straight from the table's registered
// read port, and the receiver cannot hold it off. After reset busy stays high
// while a clearing pass writes zero to every table entry, one entry per cycle.
// ----------------------------------------------------------------------------
module morse_symbol_table_decoder_core #(
    parameter int MAX_DEPTH = msdec_pkg::MAX_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [msdec_pkg::CMD_W-1:0]  i_command,
    input  logic [msdec_pkg::BITS_W-1:0] i_code_bits,
    input  logic [msdec_pkg::LEN_W-1:0]  i_code_length,
    input  logic [msdec_pkg::CHAR_W-1:0] i_entry_char,
    output logic                         o_valid,
    output logic [msdec_pkg::CHAR_W-1:0] o_decoded_char,
    output logic                         o_too_long
);

    localparam int AW = MAX_DEPTH + 1;

    msdec_pkg::t_tbl_ctrl         tbl_ctrl;
    logic [AW-1:0]                wr_addr;
    logic [msdec_pkg::CHAR_W-1:0] wr_data;
    logic [AW-1:0]                rd_addr;
    logic [msdec_pkg::CHAR_W-1:0] rd_data;
    logic                         clr_busy;
    logic                         accept;
    logic                         res_valid;
    logic                         res_ovf;

    // A word is taken when start is high outside the clearing pass.
    assign busy   = clr_busy;
    assign accept = start && !clr_busy;

    // Walk state and address generation.
    msdec_walk #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_entry_char  (i_entry_char),
        .o_ctrl        (tbl_ctrl),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .o_res_valid   (res_valid),
        .o_res_ovf     (res_ovf)
    );

    // Character table memory.
    msdec_table #(
        .AW (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (tbl_ctrl),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .o_clr_busy (clr_busy)
    );

    // An overflowed walk reports a zero character.
    assign o_valid        = res_valid;
    assign o_too_long     = res_ovf;
    assign o_decoded_char = res_ovf ? '0 : rd_data;

endmodule

[rtl/core/msdec_table.sv]
// ----------------------------------------------------------------------------
// msdec_table
// Character table of the decoder tree: one synchronous memory with a write
// port and a registered read port, plus the clearing pass after reset.
// ----------------------------------------------------------------------------
module msdec_table #(
    parameter int AW = msdec_pkg::MAX_DEPTH_DEF + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msdec_pkg::t_tbl_ctrl        i_ctrl,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [msdec_pkg::CHAR_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [msdec_pkg::CHAR_W-1:0] o_rd_data,
    output logic                        o_clr_busy
);

    localparam int DEPTH = 1 << AW;

    logic [msdec_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [msdec_pkg::CHAR_W-1:0] r_rd_data;
    logic [AW-1:0]                r_clr_addr;
    logic [AW-1:0]                n_clr_addr;
    logic                         r_clr_active;
    logic                         n_clr_active;

    // The clearing pass walks every entry once, one entry per cycle.
    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_clr_active = r_clr_active;
        if (r_clr_active) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == '1) begin
                n_clr_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_clr_active <= 1'b1;
        end else begin
            r_clr_addr   <= n_clr_addr;
            r_clr_active <= n_clr_active;
        end
    end

    // Write port: the clearing pass has the port until it is done.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_active;

endmodule

[rtl/core/msdec_walk.sv]
// ----------------------------------------------------------------------------
// msdec_walk
// Walk state of the decoder: current node, depth and overflow flag. Turns
// each accepted word into a table write for a legal path, a step down the tree
// or an overflow mark, or a table read that closes the walk.
// ----------------------------------------------------------------------------
module msdec_walk #(
    parameter int MAX_DEPTH = msdec_pkg::MAX_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [msdec_pkg::CMD_W-1:0]  i_command,
    input  logic [msdec_pkg::BITS_W-1:0] i_code_bits,
    input  logic [msdec_pkg::LEN_W-1:0]  i_code_length,
    input  logic [msdec_pkg::CHAR_W-1:0] i_entry_char,
    output msdec_pkg::t_tbl_ctrl         o_ctrl,
    output logic [MAX_DEPTH:0]           o_wr_addr,
    output logic [msdec_pkg::CHAR_W-1:0] o_wr_data,
    output logic [MAX_DEPTH:0]           o_rd_addr,
    output logic                         o_res_valid,
    output logic                         o_res_ovf
);

    localparam int AW = MAX_DEPTH + 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);

    msdec_pkg::t_cmd cmd;
    logic [AW-1:0]   ins_base;
    logic [AW-1:0]   ins_off;
    logic            ins_ok;

    logic [AW-1:0]   r_node;
    logic [AW-1:0]   n_node;
    logic [DW-1:0]   r_depth;
    logic [DW-1:0]   n_depth;
    logic            r_ovf;
    logic            n_ovf;
    logic            r_res_valid;
    logic            n_res_valid;
    logic            r_res_ovf;
    logic            n_res_ovf;

    assign cmd = msdec_pkg::t_cmd'(i_command);

    // A path of L symbols lands at node 2^L - 1 plus the path read with the
    // first symbol as the most significant bit. Path bits beyond the field
    // count as dots.
    always_comb begin
        ins_off = '0;
        for (int i = 0; i < msdec_pkg::BITS_W; i++) begin
            if (i < int'(i_code_length) && i < MAX_DEPTH) begin
                ins_off = ins_off
                        | (AW'(i_code_bits[i]) << (int'(i_code_length) - 1 - i));
            end
        end
        ins_base = (AW'(1) << i_code_length) - AW'(1);
        ins_ok   = (i_code_length != '0) && (int'(i_code_length) <= MAX_DEPTH);
    end

    // Next walk state and memory access for the accepted word.
    always_comb begin
        n_node      = r_node;
        n_depth     = r_depth;
        n_ovf       = r_ovf;
        n_res_valid = 1'b0;
        n_res_ovf   = r_res_ovf;
        o_ctrl      = '0;
        if (i_accept) begin
            unique case (cmd)
                msdec_pkg::CMD_INSERT: begin
                    o_ctrl.wr_en = ins_ok;
                end
                msdec_pkg::CMD_DOT, msdec_pkg::CMD_DASH: begin
                    if (r_ovf || (r_depth >= DW'(MAX_DEPTH))) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_node  = (r_node << 1)
                                + ((cmd == msdec_pkg::CMD_DASH) ? AW'(2) : AW'(1));
                        n_depth = r_depth + DW'(1);
                    end
                end
                msdec_pkg::CMD_FINISH: begin
                    o_ctrl.rd_en = 1'b1;
                    n_res_valid  = 1'b1;
                    n_res_ovf    = r_ovf;
                    n_node       = '0;
                    n_depth      = '0;
                    n_ovf        = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node      <= '0;
            r_depth     <= '0;
            r_ovf       <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_ovf   <= 1'b0;
        end else begin
            r_node      <= n_node;
            r_depth     <= n_depth;
            r_ovf       <= n_ovf;
            r_res_valid <= n_res_valid;
            r_res_ovf   <= n_res_ovf;
        end
    end

    assign o_wr_addr   = ins_base + ins_off;
    assign o_wr_data   = i_entry_char;
    assign o_rd_addr   = r_node;
    assign o_res_valid = r_res_valid;
    assign o_res_ovf   = r_res_ovf;

endmodule

[verif/tb_morse_symbol_table_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_symbol_table_decoder_core
// Self-checking bench for the dot/dash tree decoder. Words go in through the
// start/busy handshake. A local model of the character tree and of the walk
// state predicts every decoded character, and a checker compares each strobed
// result with the oldest prediction. Directed words cover the edge cases, then
// random walks, inserts and noise run under several sender idle patterns.
// ----------------------------------------------------------------------------
module tb_morse_symbol_table_decoder_core;

    localparam int TREE_DEPTH = msdec_pkg::MAX_DEPTH_DEF;
    localparam int TREE_SIZE  = 1 << (TREE_DEPTH + 1);

    // One decoded result word.
    typedef struct {
        logic [msdec_pkg::CHAR_W-1:0] ch;
        logic                         too_long;
    } t_decode;

    logic                         i_clk;
    logic                         i_rst_n        = 1'b0;
    logic                         start          = 1'b0;
    logic                         busy;
    logic [msdec_pkg::CMD_W-1:0]  i_command      = msdec_pkg::CMD_INSERT;
    logic [msdec_pkg::BITS_W-1:0] i_code_bits    = '0;
    logic [msdec_pkg::LEN_W-1:0]  i_code_length  = '0;
    logic [msdec_pkg::CHAR_W-1:0] i_entry_char   = '0;
    logic                         o_valid;
    logic [msdec_pkg::CHAR_W-1:0] o_decoded_char;
    logic                         o_too_long;

    // Local copy of the character tree and of the walk state.
    logic [msdec_pkg::CHAR_W-1:0] tree_chars [TREE_SIZE];
    logic [6:0]                   walk_node;
    int                           walk_depth;
    logic                         walk_over;

    t_decode pending_decodes[$];
    int      idle_pct        = 0;
    int      words_sent      = 0;
    int      decodes_checked = 0;
    int      overflow_walks  = 0;
    int      fail_count      = 0;

    morse_symbol_table_decoder_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_code_bits    (i_code_bits),
        .i_code_length  (i_code_length),
        .i_entry_char   (i_entry_char),
        .o_valid        (o_valid),
        .o_decoded_char (o_decoded_char),
        .o_too_long     (o_too_long)
    );

    // Free-running clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Heap-ordered child: a dot goes to 2n+1, a dash to 2n+2.
    function automatic logic [6:0] child_node(input logic [6:0] node, input logic dash);
        return 7'((node << 1) + (dash ? 2 : 1));
    endfunction

    // Update the tree model for one accepted word and queue any decode.
    task automatic predict_decode(input msdec_pkg::t_cmd cmd,
                                  input logic [msdec_pkg::BITS_W-1:0] bits,
                                  input logic [msdec_pkg::LEN_W-1:0] len,
                                  input logic [msdec_pkg::CHAR_W-1:0] ch);
        logic [6:0] node;
        t_decode    want;
        node = '0;
        case (cmd)
            msdec_pkg::CMD_INSERT: begin
                // Zero-length and too-deep paths leave the tree untouched.
                if (len != 0 && len <= TREE_DEPTH) begin
                    for (int i = 0; i < len; i++)
                        node = child_node(node, bits[i]);
                    tree_chars[node] = ch;
                end
            end
            msdec_pkg::CMD_DOT, msdec_pkg::CMD_DASH: begin
                // Past the deepest level the walk stays put and is flagged.
                if (walk_over || walk_depth >= TREE_DEPTH) begin
                    walk_over = 1'b1;
                end else begin
                    walk_node  = child_node(walk_node, cmd == msdec_pkg::CMD_DASH);
                    walk_depth = walk_depth + 1;
                end
            end
            default: begin
                want.ch       = walk_over ? '0 : tree_chars[walk_node];
                want.too_long = walk_over;
                if (walk_over)
                    overflow_walks++;
                pending_decodes.push_back(want);
                walk_node  = '0;
                walk_depth = 0;
                walk_over  = 1'b0;
            end
        endcase
    endtask

    // Send one word; each cycle before it is idle with the chosen chance.
    task automatic send_word(input msdec_pkg::t_cmd cmd,
                             input logic [msdec_pkg::BITS_W-1:0] bits,
                             input logic [msdec_pkg::LEN_W-1:0] len,
                             input logic [msdec_pkg::CHAR_W-1:0] ch);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_command     <= cmd;
        i_code_bits   <= bits;
        i_code_length <= len;
        i_entry_char  <= ch;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_decode(cmd, bits, len, ch);
        words_sent++;
    endtask

    // Symbol word with don't-care fields randomized.
    task automatic send_symbol(input msdec_pkg::t_cmd cmd);
        send_word(cmd, 6'($urandom_range(63)), 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    // Insert a random character, mostly on legal paths.
    task automatic send_random_insert();
        logic [msdec_pkg::LEN_W-1:0] len;
        if ($urandom_range(99) < 88)
            len = 3'($urandom_range(1, TREE_DEPTH));
        else
            len = ($urandom_range(1) != 0) ? 3'd7 : 3'd0;
        send_word(msdec_pkg::CMD_INSERT, 6'($urandom_range(63)), len,
                  8'($urandom_range(255)));
    endtask

    // Walk a random path of the given length, with occasional inserts, and finish it.
    task automatic send_walk(input int n_sym);
        for (int i = 0; i < n_sym; i++) begin
            if ($urandom_range(99) < 8)
                send_random_insert();
            send_symbol(($urandom_range(1) != 0) ? msdec_pkg::CMD_DASH : msdec_pkg::CMD_DOT);
        end
        send_symbol(msdec_pkg::CMD_FINISH);
    endtask

    // Lower start and wait until every queued decode has come back.
    task automatic drain_decodes();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge i_clk);
    endtask

    // Edge cases: empty and oversized inserts, full-depth paths, overflow.
    task automatic test_directed();
        idle_pct = 0;
        send_word(msdec_pkg::CMD_INSERT, 6'h00, 3'd0, 8'hAA);
        send_symbol(msdec_pkg::CMD_FINISH);
        send_word(msdec_pkg::CMD_INSERT, 6'h00, 3'd7, 8'h55);
        send_word(msdec_pkg::CMD_INSERT, 6'h3F, 3'd6, 8'hFF);
        // Insert in the middle of a walk; upper path bits are ignored.
        send_symbol(msdec_pkg::CMD_DOT);
        send_word(msdec_pkg::CMD_INSERT, 6'h3E, 3'd1, "E");
        send_symbol(msdec_pkg::CMD_FINISH);
        repeat (TREE_DEPTH) send_symbol(msdec_pkg::CMD_DASH);
        send_symbol(msdec_pkg::CMD_FINISH);
        repeat (TREE_DEPTH + 1) send_symbol(msdec_pkg::CMD_DASH);
        send_symbol(msdec_pkg::CMD_FINISH);
        drain_decodes();
    endtask

    // Mostly well-formed walks with random content, plus inserts and noise.
    task automatic test_random(input int n_words, input int pct);
        int target;
        int pick;
        idle_pct = pct;
        target   = words_sent + n_words;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 25)
                send_random_insert();
            else if (pick < 88)
                send_walk(($urandom_range(99) < 88) ? $urandom_range(0, TREE_DEPTH)
                                                    : $urandom_range(TREE_DEPTH + 1, 9));
            else
                send_word(msdec_pkg::t_cmd'($urandom_range(3)), 6'($urandom_range(63)),
                          3'($urandom_range(7)), 8'($urandom_range(255)));
        end
    endtask

    // The sender pauses until all results are back, then resumes.
    task automatic test_paused_sender();
        idle_pct = 0;
        send_walk(3);
        send_walk(TREE_DEPTH);
        drain_decodes();
        send_walk(2);
        send_walk(TREE_DEPTH + 2);
    endtask

    // Compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin : check_decodes
        t_decode want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_decodes.size() == 0) begin
                $error("unexpected result: decoded_char %0h too_long %0b",
                       o_decoded_char, o_too_long);
                fail_count++;
            end else begin
                want = pending_decodes.pop_front();
                decodes_checked++;
                if (o_decoded_char !== want.ch) begin
                    $error("decoded_char mismatch: expected %0h, actual %0h",
                           want.ch, o_decoded_char);
                    fail_count++;
                end
                if (o_too_long !== want.too_long) begin
                    $error("too_long mismatch: expected %0b, actual %0b",
                           want.too_long, o_too_long);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        int wait_cycles;
        for (int i = 0; i < TREE_SIZE; i++)
            tree_chars[i] = '0;
        walk_node  = '0;
        walk_depth = 0;
        walk_over  = 1'b0;

        // Hold reset, then release it on a falling clock edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(400, 0);
        test_random(400, 68);
        test_paused_sender();
        test_random(400, 35);

        // Let the last results come back, then report any that never arrived.
        @(negedge i_clk);
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_decodes.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        while (pending_decodes.size() != 0) begin
            void'(pending_decodes.pop_front());
            $error("decoded result never arrived");
            fail_count++;
        end

        $display("Sent %0d words over directed, unthrottled, throttled and paused phases.",
                 words_sent);
        $display("Checked %0d decoded results, %0d of them from walks that went too deep.",
                 decodes_checked, overflow_walks);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog in case the handshake hangs.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
